>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the adaptive Rice encoder checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define ARENC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset
`define ARENC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/arenc_pkg.sv
// ----------------------------------------------------------------------------
// arenc_pkg
// Types, widths and helper functions shared by the adaptive Rice encoder.
// ----------------------------------------------------------------------------
package arenc_pkg;

	localparam int WORD_BITS = 8;   // bits in one input byte
	localparam int CODE_W    = 23;  // width of the code_bits port
	localparam int LEN_W     = 5;   // width of the code_length port
	localparam int K_W       = 4;   // width of a Rice parameter
	localparam int NB_W      = 4;   // width of a byte bit length (0..8)
	localparam int CW_W      = 32;  // internal codeword width (length <= 31)

	typedef logic [WORD_BITS-1:0] byte_t;
	typedef logic [K_W-1:0]       k_t;
	typedef logic [NB_W-1:0]      nb_t;

	// Window control from the top level to the k adaptation unit
	typedef struct packed {
		logic step;     // item in the input stage moves on this cycle
		logic restart;  // that item starts a new block
	} win_ctl_t;

	// Position of the leading one plus one, zero for zero
	function automatic nb_t bit_len8(input byte_t v);
		nb_t n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) begin
				n = nb_t'(i + 1);
			end
		end
		return n;
	endfunction

	// Keep k within 1..8
	function automatic k_t clamp_k(input k_t v);
		k_t r;
		if (v == '0) begin
			r = k_t'(1);
		end else if (v > k_t'(WORD_BITS)) begin
			r = k_t'(WORD_BITS);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> rtl/arenc_kadapt.sv
// ----------------------------------------------------------------------------
// arenc_kadapt
// Window state and Rice parameter selection: fill count, running sum of
// byte bit lengths and a shift line holding the last HISTORY lengths.
// ----------------------------------------------------------------------------
module arenc_kadapt #(
	parameter int HISTORY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  arenc_pkg::win_ctl_t ctl,
	input  arenc_pkg::byte_t   data_byte,
	input  arenc_pkg::k_t      initial_k,
	output arenc_pkg::k_t      k
);
	import arenc_pkg::*;

	localparam int SUM_W  = $clog2(HISTORY * WORD_BITS + 1);
	localparam int RND_W  = $clog2(HISTORY * WORD_BITS + HISTORY / 2 + 1);
	localparam int FILL_W = $clog2(HISTORY + 1);

	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;
	nb_t               hist_q [HISTORY];

	logic [FILL_W-1:0] fill_eff;
	logic [SUM_W-1:0]  sum_eff;
	logic [SUM_W-1:0]  sum_next;
	logic [RND_W-1:0]  rnd;
	logic              full;
	k_t                mean_k;
	nb_t               nb;

	// Restart clears the window before this item is coded
	assign fill_eff = ctl.restart ? '0 : fill_q;
	assign sum_eff  = ctl.restart ? '0 : sum_q;
	assign full     = (fill_eff == FILL_W'(HISTORY));

	// Rounded mean: count the multiples of HISTORY the rounded sum reaches
	always_comb begin
		rnd    = RND_W'(sum_eff) + RND_W'(HISTORY / 2);
		mean_k = '0;
		for (int j = 1; j <= WORD_BITS; j++) begin
			if (rnd >= RND_W'(j * HISTORY)) begin
				mean_k = k_t'(j);
			end
		end
	end

	assign k = full ? clamp_k(mean_k) : clamp_k(initial_k);

	// Running sum: drop the oldest length once the window is full
	assign nb       = bit_len8(data_byte);
	assign sum_next = sum_eff - (full ? SUM_W'(hist_q[HISTORY-1]) : '0) + SUM_W'(nb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (ctl.step) begin
			fill_q <= full ? fill_eff : fill_eff + FILL_W'(1);
			sum_q  <= sum_next;
		end
	end

	// Length history shift line, oldest entry at the far end
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			hist_q[0] <= nb;
			for (int i = 1; i < HISTORY; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

endmodule

>>> rtl/arenc_coder.sv
// ----------------------------------------------------------------------------
// arenc_coder
// Builds the Rice codeword for one byte and k: unary quotient, or an
// escaped bit-length code for large quotients, then the k low bits.
// ----------------------------------------------------------------------------
module arenc_coder #(
	parameter int THRESHOLD = 8
) (
	input  arenc_pkg::byte_t          data_byte,
	input  arenc_pkg::k_t             k,
	output logic [arenc_pkg::CODE_W-1:0] code_bits,
	output logic [arenc_pkg::LEN_W-1:0]  code_length
);
	import arenc_pkg::*;

	// n low ones
	function automatic logic [CW_W-1:0] ones(input logic [5:0] n);
		return (CW_W'(1) << n) - CW_W'(1);
	endfunction

	byte_t           q;
	byte_t           r;
	nb_t             o;
	logic [5:0]      o_m1;
	logic            esc;
	logic [CW_W-1:0] prefix;
	logic [5:0]      plen;
	logic [CW_W-1:0] cw;
	logic [5:0]      len;

	assign q     = data_byte >> k;
	assign esc   = (q > byte_t'(THRESHOLD));
	assign r     = q - byte_t'(THRESHOLD);
	assign o     = bit_len8(r);
	assign o_m1  = (o == '0) ? '0 : 6'(o) - 6'd1;

	// Quotient part
	always_comb begin
		if (esc) begin
			prefix = (ones(6'(THRESHOLD) + 6'(o)) << o) | (CW_W'(r) & ones(o_m1));
			plen   = 6'(THRESHOLD) + 6'(o) + 6'(o);
		end else begin
			prefix = ones(6'(q)) << 1;
			plen   = 6'(q) + 6'd1;
		end
	end

	// Append the k remainder bits
	assign cw  = (prefix << k) | (CW_W'(data_byte) & ones(6'(k)));
	assign len = plen + 6'(k);

	assign code_bits   = cw[CODE_W-1:0];
	assign code_length = len[LEN_W-1:0];

endmodule

>>> rtl/adaptive_rice_encoder.sv
// ----------------------------------------------------------------------------
// adaptive_rice_encoder
// Adaptive Rice encoder: one byte in, one right-aligned codeword out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries data_byte and restart. A set
//   restart clears the length window before that byte is coded.
//   Output channel out_valid/out_ready carries code_bits (MSB first,
//   right-aligned), code_length and k_used.
//   Config channel cfg_valid/cfg_ready writes initial_k (cfg_data), always
//   ready. The user writes it only while no item is in flight; the block does not enforce this.
// Timing:
//   An accepted item passes from the input register to the output register
//   and is then shown with out_valid; one item per cycle is sustained while
//   out_ready stays high.
//   The input register feeds the k selection and codeword logic, which
//   loads the output register; window state updates in the same cycle.
// Reset and stall:
//   Reset empties both stages, clears the window and sets initial_k to 1.
//   While out_ready is low the result holds; one more item is taken into
//   the input stage, then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module adaptive_rice_encoder #(
	parameter int HISTORY   = 16,
	parameter int THRESHOLD = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  arenc_pkg::k_t                 cfg_data,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  arenc_pkg::byte_t              data_byte,
	input  logic                          restart,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [arenc_pkg::CODE_W-1:0]  code_bits,
	output logic [arenc_pkg::LEN_W-1:0]   code_length,
	output arenc_pkg::k_t                 k_used
);
	import arenc_pkg::*;

	k_t                initial_k_q;
	logic              valid_s1;
	byte_t             data_s1;
	logic              restart_s1;
	logic              valid_s2;
	logic [CODE_W-1:0] code_bits_s2;
	logic [LEN_W-1:0]  code_length_s2;
	k_t                k_s2;

	logic              adv_out;
	win_ctl_t          win_ctl;
	k_t                k_cur;
	logic [CODE_W-1:0] cw_cur;
	logic [LEN_W-1:0]  len_cur;

	// Config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_k_q <= k_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			initial_k_q <= cfg_data;
		end
	end

	// Handshake: output register frees up, input stage moves into it
	assign adv_out         = !valid_s2 || out_ready;
	assign in_ready        = !valid_s1 || adv_out;
	assign win_ctl.step    = valid_s1 && adv_out;
	assign win_ctl.restart = restart_s1;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	arenc_kadapt #(
		.HISTORY(HISTORY)
	) u_kadapt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (win_ctl),
		.data_byte(data_s1),
		.initial_k(initial_k_q),
		.k        (k_cur)
	);

	arenc_coder #(
		.THRESHOLD(THRESHOLD)
	) u_coder (
		.data_byte  (data_s1),
		.k          (k_cur),
		.code_bits  (cw_cur),
		.code_length(len_cur)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_out) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (win_ctl.step) begin
			code_bits_s2   <= cw_cur;
			code_length_s2 <= len_cur;
			k_s2           <= k_cur;
		end
	end

	assign out_valid   = valid_s2;
	assign code_bits   = code_bits_s2;
	assign code_length = code_length_s2;
	assign k_used      = k_s2;

endmodule

>>> rtl/arenc_checker.sv
// ----------------------------------------------------------------------------
// arenc_checker
// Port-level checks for the adaptive Rice encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arenc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [arenc_pkg::CODE_W-1:0] code_bits,
	input logic [arenc_pkg::LEN_W-1:0]  code_length,
	input arenc_pkg::k_t                k_used
);
	import arenc_pkg::*;

	// No result is shown while reset is held
	`ARENC_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |-> !out_valid, "result valid during reset")

	// A stalled result holds its value
	`ARENC_ASSERT(a_stall_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(code_bits) && $stable(code_length) && $stable(k_used), "stalled result changed")

	// k stays within 1..8
	`ARENC_ASSERT(a_k_range, clk, arst_n, out_valid |-> (k_used >= k_t'(1)) && (k_used <= k_t'(WORD_BITS)), "k out of range")

	// Codeword holds at least the terminator or escape plus the k low bits
	`ARENC_ASSERT(a_len_min, clk, arst_n, out_valid |-> code_length > LEN_W'(k_used), "code length too short")

	// With the output stage empty, input is never blocked
	`ARENC_ASSERT(a_ready_free, clk, arst_n, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind adaptive_rice_encoder arenc_checker u_arenc_checker (.*);
